### src/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types, widths, codes and reset values of the tunnel lease table.
// ----------------------------------------------------------------------------
package tlt_pkg;

	localparam int POOL_SIZE   = 254;
	localparam int SLOT_W      = 8;
	localparam int KIND_W      = 2;
	localparam int IP_W        = 32;
	localparam int PORT_W      = 16;
	localparam int LEN_W       = 13;
	localparam int STATUS_W    = 3;
	localparam int STAMP_W     = 32;
	localparam int TTL_W       = 16;
	localparam int PERIOD_W    = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int RMT_W       = IP_W + PORT_W;
	localparam int MIN_LEN     = 20;
	localparam int SLOT_OFFSET = 2;

	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam status_t ST_KNOWN      = 3'd0;
	localparam status_t ST_NEW_LEASE  = 3'd1;
	localparam status_t ST_POOL_FULL  = 3'd2;
	localparam status_t ST_FORWARDED  = 3'd3;
	localparam status_t ST_LOCAL_DROP = 3'd4;
	localparam status_t ST_TICK_DONE  = 3'd5;

	localparam kind_t KIND_REMOTE = 2'd0;
	localparam kind_t KIND_LOCAL  = 2'd1;
	localparam kind_t KIND_TICK   = 2'd2;

	localparam cfg_idx_t CFG_TTL    = 2'd0;
	localparam cfg_idx_t CFG_PERIOD = 2'd1;
	localparam cfg_idx_t CFG_BASE   = 2'd2;

	localparam logic [TTL_W-1:0]    TTL_RESET    = 16'd300;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
	localparam logic [IP_W-1:0]     BASE_RESET   = 32'h0A00_0000;

endpackage

### src/tlt_ram.sv
// ----------------------------------------------------------------------------
// tlt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tlt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/tunnel_lease_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// tunnel_lease_table_with_aging_top
// Lease table of remote endpoints with tunnel address assignment and aging.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A remote packet, and a tick that falls on
// a sweep, scans every lease once through the single read port of the lease
// memories, one entry per cycle. A forwarded local packet reads its lease in
// S_LREAD before S_FINISH; a dropped local packet, an unused kind and a tick
// without a sweep go straight to S_FINISH. The input stalls from accept until
// the result is registered. The result sits in an output register, so the
// next item is taken while it waits; a held result only delays the finish of
// the item behind it. Active bits live in flip-flops that reset clears, so
// the block is ready right after reset with no clearing pass.
module tunnel_lease_table_with_aging_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tlt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tlt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tlt_pkg::KIND_W-1:0]          kind,
	input  logic [tlt_pkg::IP_W-1:0]            remote_ip,
	input  logic [tlt_pkg::PORT_W-1:0]          peer_port,
	input  logic [tlt_pkg::IP_W-1:0]            dest_ip,
	input  logic [tlt_pkg::LEN_W-1:0]           packet_length,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tlt_pkg::STATUS_W-1:0]        status,
	output logic [tlt_pkg::SLOT_W-1:0]          slot,
	output logic [tlt_pkg::IP_W-1:0]            tunnel_ip,
	output logic [tlt_pkg::IP_W-1:0]            out_remote_ip,
	output logic [tlt_pkg::PORT_W-1:0]          out_peer_port
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LREAD,
		S_FINISH
	} state_t;

	localparam logic [tlt_pkg::SLOT_W-1:0] LAST_SLOT =
		tlt_pkg::SLOT_W'(tlt_pkg::POOL_SIZE - 1);

	state_t                           state_q;
	logic [tlt_pkg::TTL_W-1:0]        ttl_q;
	logic [tlt_pkg::PERIOD_W-1:0]     period_q;
	logic [tlt_pkg::IP_W-1:0]         base_q;
	logic [tlt_pkg::STAMP_W-1:0]      now_q;
	logic [tlt_pkg::PERIOD_W-1:0]     cnt_q;
	logic [tlt_pkg::POOL_SIZE-1:0]    active_q;
	logic [tlt_pkg::POOL_SIZE-1:0]    stale_q;

	tlt_pkg::kind_t                   kind_q;
	logic [tlt_pkg::IP_W-1:0]         rip_q;
	logic [tlt_pkg::PORT_W-1:0]       rport_q;
	logic                             lok_q;
	logic                             sweep_q;
	logic [tlt_pkg::SLOT_W-1:0]       lslot_q;
	logic [tlt_pkg::IP_W-1:0]         lrip_q;
	logic [tlt_pkg::PORT_W-1:0]       lport_q;

	logic                             issue_q;
	logic [tlt_pkg::SLOT_W-1:0]       rd_idx_q;
	logic                             vld_s1;
	logic [tlt_pkg::SLOT_W-1:0]       idx_s1;
	logic                             found_q;
	logic [tlt_pkg::SLOT_W-1:0]       hit_slot_q;
	logic                             free_q;
	logic [tlt_pkg::SLOT_W-1:0]       free_slot_q;

	logic                             out_valid_q;
	tlt_pkg::status_t                 status_q;
	logic [tlt_pkg::SLOT_W-1:0]       slot_q;
	logic [tlt_pkg::IP_W-1:0]         tip_q;
	logic [tlt_pkg::IP_W-1:0]         orip_q;
	logic [tlt_pkg::PORT_W-1:0]       oport_q;

	logic                             in_fire;
	logic                             out_free;
	logic [tlt_pkg::SLOT_W-1:0]       local_slot;
	logic                             local_ok;
	logic [tlt_pkg::STAMP_W-1:0]      now_next;
	logic [tlt_pkg::PERIOD_W-1:0]     cnt_next;
	logic [tlt_pkg::PERIOD_W-1:0]     period_eff;
	logic                             sweep_now;

	logic [tlt_pkg::SLOT_W-1:0]       raddr;
	logic [tlt_pkg::RMT_W-1:0]        rmt_rdata;
	logic [tlt_pkg::STAMP_W-1:0]      stamp_rdata;
	logic [tlt_pkg::STAMP_W-1:0]      age;
	logic                             ent_active;
	logic                             ent_hit;
	logic                             ent_stale;

	tlt_pkg::status_t                 fin_status;
	logic [tlt_pkg::SLOT_W-1:0]       fin_slot;
	logic                             fin_has_slot;
	logic [tlt_pkg::IP_W-1:0]         fin_rip;
	logic [tlt_pkg::PORT_W-1:0]       fin_rport;
	logic                             fin_clear;
	logic                             fin_set;
	logic                             stamp_we;
	logic                             rmt_we;
	logic [tlt_pkg::POOL_SIZE-1:0]    active_next;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign tunnel_ip       = tip_q;
	assign out_remote_ip   = orip_q;
	assign out_peer_port   = oport_q;

	assign local_slot = dest_ip[tlt_pkg::SLOT_W-1:0] - tlt_pkg::SLOT_W'(tlt_pkg::SLOT_OFFSET);
	assign local_ok   = (packet_length > tlt_pkg::LEN_W'(tlt_pkg::MIN_LEN))
	                    && (dest_ip[tlt_pkg::SLOT_W-1:0] >= tlt_pkg::SLOT_W'(tlt_pkg::SLOT_OFFSET))
	                    && (local_slot < tlt_pkg::SLOT_W'(tlt_pkg::POOL_SIZE))
	                    && active_q[local_slot];

	assign now_next   = now_q + tlt_pkg::STAMP_W'(1);
	assign cnt_next   = cnt_q + tlt_pkg::PERIOD_W'(1);
	assign period_eff = (period_q == '0) ? tlt_pkg::PERIOD_W'(1) : period_q;
	assign sweep_now  = (cnt_next >= period_eff);

	assign raddr = (state_q == S_IDLE) ? local_slot : rd_idx_q;

	// Compare unit shared by every scan step
	assign age        = now_q - stamp_rdata;
	assign ent_active = active_q[idx_s1];
	assign ent_hit    = ent_active && (kind_q == tlt_pkg::KIND_REMOTE)
	                    && (rmt_rdata == {rip_q, rport_q});
	assign ent_stale  = ent_active && (age > {{(tlt_pkg::STAMP_W - tlt_pkg::TTL_W){1'b0}}, ttl_q});

	always_comb begin
		fin_status   = tlt_pkg::ST_LOCAL_DROP;
		fin_slot     = '0;
		fin_has_slot = 1'b0;
		fin_rip      = '0;
		fin_rport    = '0;
		fin_clear    = 1'b0;
		fin_set      = 1'b0;
		stamp_we     = 1'b0;
		rmt_we       = 1'b0;
		priority if (kind_q == tlt_pkg::KIND_REMOTE) begin
			if (found_q) begin
				fin_status   = tlt_pkg::ST_KNOWN;
				fin_slot     = hit_slot_q;
				fin_has_slot = 1'b1;
				stamp_we     = 1'b1;
			end else begin
				fin_clear = 1'b1;
				if (free_q) begin
					fin_status   = tlt_pkg::ST_NEW_LEASE;
					fin_slot     = free_slot_q;
					fin_has_slot = 1'b1;
					fin_set      = 1'b1;
					stamp_we     = 1'b1;
					rmt_we       = 1'b1;
				end else begin
					fin_status = tlt_pkg::ST_POOL_FULL;
				end
			end
		end else if (kind_q == tlt_pkg::KIND_LOCAL && lok_q) begin
			fin_status   = tlt_pkg::ST_FORWARDED;
			fin_slot     = lslot_q;
			fin_has_slot = 1'b1;
			fin_rip      = lrip_q;
			fin_rport    = lport_q;
			stamp_we     = 1'b1;
		end else if (kind_q == tlt_pkg::KIND_TICK) begin
			fin_status = tlt_pkg::ST_TICK_DONE;
			fin_clear  = sweep_q;
		end else begin
			fin_status = tlt_pkg::ST_LOCAL_DROP;
		end
	end

	always_comb begin
		active_next = active_q;
		if (fin_clear) begin
			active_next = active_q & ~stale_q;
		end
		if (fin_set) begin
			active_next[fin_slot] = 1'b1;
		end
	end

	tlt_ram #(
		.WIDTH (tlt_pkg::RMT_W),
		.DEPTH (tlt_pkg::POOL_SIZE)
	) u_rmt_ram (
		.clk   (clk),
		.we    (rmt_we && state_q == S_FINISH && out_free),
		.waddr (fin_slot),
		.wdata ({rip_q, rport_q}),
		.raddr (raddr),
		.rdata (rmt_rdata)
	);

	tlt_ram #(
		.WIDTH (tlt_pkg::STAMP_W),
		.DEPTH (tlt_pkg::POOL_SIZE)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we && state_q == S_FINISH && out_free),
		.waddr (fin_slot),
		.wdata (now_q),
		.raddr (raddr),
		.rdata (stamp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ttl_q       <= tlt_pkg::TTL_RESET;
			period_q    <= tlt_pkg::PERIOD_RESET;
			base_q      <= tlt_pkg::BASE_RESET;
			now_q       <= '0;
			cnt_q       <= '0;
			active_q    <= '0;
			stale_q     <= '0;
			kind_q      <= tlt_pkg::KIND_REMOTE;
			rip_q       <= '0;
			rport_q     <= '0;
			lok_q       <= 1'b0;
			sweep_q     <= 1'b0;
			lslot_q     <= '0;
			lrip_q      <= '0;
			lport_q     <= '0;
			issue_q     <= 1'b0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			hit_slot_q  <= '0;
			free_q      <= 1'b0;
			free_slot_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= tlt_pkg::ST_KNOWN;
			slot_q      <= '0;
			tip_q       <= '0;
			orip_q      <= '0;
			oport_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tlt_pkg::CFG_TTL:    ttl_q    <= cfg_wdata[tlt_pkg::TTL_W-1:0];
					tlt_pkg::CFG_PERIOD: period_q <= cfg_wdata[tlt_pkg::PERIOD_W-1:0];
					tlt_pkg::CFG_BASE:   base_q   <= cfg_wdata[tlt_pkg::IP_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			vld_s1 <= issue_q && (state_q == S_SCAN);
			idx_s1 <= rd_idx_q;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						kind_q      <= kind;
						rip_q       <= remote_ip;
						rport_q     <= peer_port;
						lok_q       <= local_ok;
						lslot_q     <= local_slot;
						sweep_q     <= (kind == tlt_pkg::KIND_TICK) && sweep_now;
						rd_idx_q    <= '0;
						found_q     <= 1'b0;
						free_q      <= 1'b0;
						unique case (kind)
							tlt_pkg::KIND_REMOTE: begin
								issue_q <= 1'b1;
								state_q <= S_SCAN;
							end
							tlt_pkg::KIND_LOCAL: begin
								state_q <= local_ok ? S_LREAD : S_FINISH;
							end
							tlt_pkg::KIND_TICK: begin
								now_q   <= now_next;
								cnt_q   <= sweep_now ? '0 : cnt_next;
								issue_q <= sweep_now;
								state_q <= sweep_now ? S_SCAN : S_FINISH;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						rd_idx_q <= rd_idx_q + tlt_pkg::SLOT_W'(1);
						if (rd_idx_q == LAST_SLOT) begin
							issue_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						stale_q[idx_s1] <= ent_stale;
						if (ent_hit && !found_q) begin
							found_q    <= 1'b1;
							hit_slot_q <= idx_s1;
						end
						if ((!ent_active || ent_stale) && !free_q) begin
							free_q      <= 1'b1;
							free_slot_q <= idx_s1;
						end
						if (idx_s1 == LAST_SLOT) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_LREAD: begin
					lrip_q  <= rmt_rdata[tlt_pkg::RMT_W-1:tlt_pkg::PORT_W];
					lport_q <= rmt_rdata[tlt_pkg::PORT_W-1:0];
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						active_q    <= active_next;
						status_q    <= fin_status;
						slot_q      <= fin_slot;
						tip_q       <= fin_has_slot
						               ? base_q + {{(tlt_pkg::IP_W - tlt_pkg::SLOT_W){1'b0}}, fin_slot}
						                 + tlt_pkg::IP_W'(tlt_pkg::SLOT_OFFSET)
						               : '0;
						orip_q      <= fin_rip;
						oport_q     <= fin_rport;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tunnel lease table with aging.
// A short table of hand-picked beats runs first at reset settings, with the
// answer typed in where it is obvious. Six random phases follow, each at new
// register settings. They cover a full pool, zero ttl and zero sweep period,
// a period lowered below the running count, and a tunnel base that wraps.
// Each result is checked field by field against its typed answer, else the
// in-bench lease model. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb;

	localparam tlt_pkg::kind_t KIND_SPARE = 2'd3;
	localparam int    CYCLE_LIMIT = 3_000_000;
	localparam int    DRAIN_HOLD  = 300;
	localparam int    LEN_MAX     = (1 << tlt_pkg::LEN_W) - 1;

	typedef struct packed {
		tlt_pkg::kind_t             kind;
		logic [tlt_pkg::IP_W-1:0]   rip;
		logic [tlt_pkg::PORT_W-1:0] rport;
		logic [tlt_pkg::IP_W-1:0]   dip;
		logic [tlt_pkg::LEN_W-1:0]  plen;
	} packet_t;

	typedef struct packed {
		tlt_pkg::status_t           status;
		logic [tlt_pkg::SLOT_W-1:0] slot;
		logic [tlt_pkg::IP_W-1:0]   tip;
		logic [tlt_pkg::IP_W-1:0]   fwd_ip;
		logic [tlt_pkg::PORT_W-1:0] fwd_port;
	} verdict_t;

	typedef struct packed {
		packet_t  pkt;
		logic     typed;
		verdict_t want;
	} vector_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [tlt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tlt_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                           in_valid;
	logic                           in_stall;
	logic [tlt_pkg::KIND_W-1:0]     kind;
	logic [tlt_pkg::IP_W-1:0]       remote_ip;
	logic [tlt_pkg::PORT_W-1:0]     peer_port;
	logic [tlt_pkg::IP_W-1:0]       dest_ip;
	logic [tlt_pkg::LEN_W-1:0]      packet_length;
	logic                           out_valid;
	logic                           out_stall;
	logic [tlt_pkg::STATUS_W-1:0]   status;
	logic [tlt_pkg::SLOT_W-1:0]     slot;
	logic [tlt_pkg::IP_W-1:0]       tunnel_ip;
	logic [tlt_pkg::IP_W-1:0]       out_remote_ip;
	logic [tlt_pkg::PORT_W-1:0]     out_peer_port;

	// lease model state and its copy of the registers
	bit                           lease_on   [tlt_pkg::POOL_SIZE];
	logic [tlt_pkg::IP_W-1:0]     lease_ip   [tlt_pkg::POOL_SIZE];
	logic [tlt_pkg::PORT_W-1:0]   lease_port [tlt_pkg::POOL_SIZE];
	logic [tlt_pkg::STAMP_W-1:0]  lease_seen [tlt_pkg::POOL_SIZE];
	logic [tlt_pkg::STAMP_W-1:0]  now_sec;
	logic [tlt_pkg::PERIOD_W-1:0] sweep_cnt;
	logic [tlt_pkg::TTL_W-1:0]    ttl_reg;
	logic [tlt_pkg::PERIOD_W-1:0] period_reg;
	logic [tlt_pkg::IP_W-1:0]     base_reg;

	verdict_t pending_verdicts[$];
	vector_t  directed[$];
	int       mismatches;
	int       cycles;
	int       send_idle;
	int       recv_idle;

	tunnel_lease_table_with_aging_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: no progress, run stopped", $time);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle);

	function automatic logic [tlt_pkg::IP_W-1:0] pool_address(input int s);
		return base_reg + tlt_pkg::IP_W'(s) + tlt_pkg::IP_W'(tlt_pkg::SLOT_OFFSET);
	endfunction

	function automatic void age_out_leases();
		logic [tlt_pkg::STAMP_W-1:0] age;
		for (int i = 0; i < tlt_pkg::POOL_SIZE; i++) begin
			age = now_sec - lease_seen[i];
			if (lease_on[i] && age > tlt_pkg::STAMP_W'(ttl_reg))
				lease_on[i] = 1'b0;
		end
	endfunction

	function automatic verdict_t lease_table_step(input packet_t p);
		verdict_t                     v;
		int                           hit;
		int                           s;
		logic [tlt_pkg::PERIOD_W-1:0] period;
		v = '0;
		v.status = tlt_pkg::ST_LOCAL_DROP;
		case (p.kind)
			tlt_pkg::KIND_REMOTE: begin
				hit = -1;
				for (int i = 0; i < tlt_pkg::POOL_SIZE; i++)
					if (hit < 0 && lease_on[i] && lease_ip[i] == p.rip
						&& lease_port[i] == p.rport)
						hit = i;
				if (hit >= 0) begin
					lease_seen[hit] = now_sec;
					v.status = tlt_pkg::ST_KNOWN;
					v.slot = tlt_pkg::SLOT_W'(hit);
					v.tip = pool_address(hit);
				end else begin
					age_out_leases();
					s = -1;
					for (int i = 0; i < tlt_pkg::POOL_SIZE; i++)
						if (s < 0 && !lease_on[i])
							s = i;
					if (s >= 0) begin
						lease_on[s] = 1'b1;
						lease_ip[s] = p.rip;
						lease_port[s] = p.rport;
						lease_seen[s] = now_sec;
						v.status = tlt_pkg::ST_NEW_LEASE;
						v.slot = tlt_pkg::SLOT_W'(s);
						v.tip = pool_address(s);
					end else begin
						v.status = tlt_pkg::ST_POOL_FULL;
					end
				end
			end
			tlt_pkg::KIND_LOCAL: begin
				s = int'(p.dip[7:0]) - tlt_pkg::SLOT_OFFSET;
				if (p.plen > tlt_pkg::MIN_LEN && s >= 0 && s < tlt_pkg::POOL_SIZE
					&& lease_on[s]) begin
					lease_seen[s] = now_sec;
					v.status = tlt_pkg::ST_FORWARDED;
					v.slot = tlt_pkg::SLOT_W'(s);
					v.tip = pool_address(s);
					v.fwd_ip = lease_ip[s];
					v.fwd_port = lease_port[s];
				end
			end
			tlt_pkg::KIND_TICK: begin
				period = (period_reg == '0) ? tlt_pkg::PERIOD_W'(1) : period_reg;
				now_sec = now_sec + tlt_pkg::STAMP_W'(1);
				sweep_cnt = sweep_cnt + tlt_pkg::PERIOD_W'(1);
				if (sweep_cnt >= period) begin
					age_out_leases();
					sweep_cnt = '0;
				end
				v.status = tlt_pkg::ST_TICK_DONE;
			end
			default: begin
				v.status = tlt_pkg::ST_LOCAL_DROP;
			end
		endcase
		return v;
	endfunction

	function automatic int pick_live_slot();
		int start;
		int s;
		start = $urandom_range(0, tlt_pkg::POOL_SIZE - 1);
		for (int k = 0; k < tlt_pkg::POOL_SIZE; k++) begin
			s = (start + k) % tlt_pkg::POOL_SIZE;
			if (lease_on[s])
				return s;
		end
		return -1;
	endfunction

	function automatic packet_t draw_packet();
		packet_t p;
		int      pick;
		int      live;
		p.kind = tlt_pkg::KIND_TICK;
		p.rip = $urandom;
		p.rport = tlt_pkg::PORT_W'($urandom);
		p.dip = $urandom;
		p.plen = tlt_pkg::LEN_W'($urandom);
		live = pick_live_slot();
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			p.kind = tlt_pkg::KIND_REMOTE;
			pick = $urandom_range(0, 99);
			if (pick < 45 && live >= 0) begin
				p.rip = lease_ip[live];
				p.rport = lease_port[live];
			end else if (pick < 80) begin
				p.rip = 32'hC633_6400 + $urandom_range(0, 15);
				p.rport = 16'd5000 + tlt_pkg::PORT_W'($urandom_range(0, 3));
			end
		end else if (pick < 70) begin
			p.kind = tlt_pkg::KIND_LOCAL;
			if ($urandom_range(0, 99) < 70 && live >= 0)
				p.dip[7:0] = 8'(live + tlt_pkg::SLOT_OFFSET);
			if ($urandom_range(0, 99) < 85)
				p.plen = tlt_pkg::LEN_W'($urandom_range(tlt_pkg::MIN_LEN + 1, LEN_MAX));
			else
				p.plen = tlt_pkg::LEN_W'($urandom_range(0, tlt_pkg::MIN_LEN));
		end else if (pick >= 95) begin
			p.kind = KIND_SPARE;
		end
		return p;
	endfunction

	function automatic vector_t mk_vector(input tlt_pkg::kind_t k, input logic [31:0] rip,
		input logic [15:0] rport, input logic [31:0] dip, input int plen,
		input logic typed, input tlt_pkg::status_t st, input int s,
		input logic [31:0] tip, input logic [31:0] fip, input logic [15:0] fport);
		vector_t r;
		r.pkt = '{kind: k, rip: rip, rport: rport, dip: dip,
			plen: tlt_pkg::LEN_W'(plen)};
		r.typed = typed;
		r.want = '{status: st, slot: tlt_pkg::SLOT_W'(s), tip: tip, fwd_ip: fip,
			fwd_port: fport};
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none got status %0d slot %0d",
					$time, status, slot);
			end else begin
				want = pending_verdicts.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("slot", 32'(want.slot), 32'(slot));
				check_field("tunnel_ip", want.tip, tunnel_ip);
				check_field("out_remote_ip", want.fwd_ip, out_remote_ip);
				check_field("out_peer_port", 32'(want.fwd_port), 32'(out_peer_port));
			end
		end
	end

	// present one beat, hold it until taken, then record its answer
	task automatic offer(input packet_t p, input logic typed, input verdict_t want);
		verdict_t v;
		int       gap;
		if ($urandom_range(0, 99) < send_idle) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
				: $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= p.kind;
		remote_ip <= p.rip;
		peer_port <= p.rport;
		dest_ip <= p.dip;
		packet_length <= p.plen;
		do @(posedge clk); while (in_stall);
		v = lease_table_step(p);
		pending_verdicts.push_back(typed ? want : v);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic program_regs(input logic [tlt_pkg::TTL_W-1:0] ttl,
		input logic [tlt_pkg::PERIOD_W-1:0] per, input logic [tlt_pkg::IP_W-1:0] base);
		cfg_we <= 1'b1;
		cfg_index <= tlt_pkg::CFG_TTL;
		cfg_wdata <= tlt_pkg::CFG_DATA_W'(ttl);
		@(posedge clk);
		cfg_index <= tlt_pkg::CFG_PERIOD;
		cfg_wdata <= tlt_pkg::CFG_DATA_W'(per);
		@(posedge clk);
		cfg_index <= tlt_pkg::CFG_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
		ttl_reg = ttl;
		period_reg = per;
		base_reg = base;
	endtask

	initial begin
		packet_t                      p;
		logic [tlt_pkg::TTL_W-1:0]    ttl;
		logic [tlt_pkg::PERIOD_W-1:0] per;
		logic [tlt_pkg::IP_W-1:0]     base;
		int                           mix;
		bit                           fill;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = '0;
		remote_ip = '0;
		peer_port = '0;
		dest_ip = '0;
		packet_length = '0;
		out_stall = 1'b0;
		mismatches = 0;
		cycles = 0;
		send_idle = 20;
		recv_idle = 80;
		ttl_reg = tlt_pkg::TTL_RESET;
		period_reg = tlt_pkg::PERIOD_RESET;
		base_reg = tlt_pkg::BASE_RESET;
		now_sec = '0;
		sweep_cnt = '0;
		foreach (lease_on[i]) begin
			lease_on[i] = 1'b0;
			lease_ip[i] = '0;
			lease_port[i] = '0;
			lease_seen[i] = '0;
		end

		directed.push_back(mk_vector(tlt_pkg::KIND_REMOTE, 32'h0102_0304, 16'd1000, 0, 0,
			1, tlt_pkg::ST_NEW_LEASE, 0, 32'h0A00_0002, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_REMOTE, 32'h0102_0304, 16'd1000, 0, 0,
			1, tlt_pkg::ST_KNOWN, 0, 32'h0A00_0002, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_REMOTE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
			1, tlt_pkg::ST_NEW_LEASE, 1, 32'h0A00_0003, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_REMOTE, 32'h0, 16'h0, 0, 0,
			1, tlt_pkg::ST_NEW_LEASE, 2, 32'h0A00_0004, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_REMOTE, 32'h0102_0304, 16'd1001, 0, 0,
			1, tlt_pkg::ST_NEW_LEASE, 3, 32'h0A00_0005, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'hC0A8_0002,
			tlt_pkg::MIN_LEN + 1, 1, tlt_pkg::ST_FORWARDED, 0, 32'h0A00_0002,
			32'h0102_0304, 16'd1000));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'hFFFF_FF03, LEN_MAX,
			1, tlt_pkg::ST_FORWARDED, 1, 32'h0A00_0003, 32'hFFFF_FFFF, 16'hFFFF));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'hC0A8_0002,
			tlt_pkg::MIN_LEN, 1, tlt_pkg::ST_LOCAL_DROP, 0, 0, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'h0000_0000, 100,
			1, tlt_pkg::ST_LOCAL_DROP, 0, 0, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'h0000_0001, 100,
			1, tlt_pkg::ST_LOCAL_DROP, 0, 0, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'hFFFF_FFFF, 4096,
			1, tlt_pkg::ST_LOCAL_DROP, 0, 0, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'h7F00_0010, 4096,
			1, tlt_pkg::ST_LOCAL_DROP, 0, 0, 0, 0));
		directed.push_back(mk_vector(KIND_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FF02,
			LEN_MAX, 1, tlt_pkg::ST_LOCAL_DROP, 0, 0, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_TICK, 32'hFFFF_FFFF, 16'hFFFF,
			32'hFFFF_FF02, LEN_MAX, 1, tlt_pkg::ST_TICK_DONE, 0, 0, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_REMOTE, 32'h0, 16'h0, 0, 0,
			1, tlt_pkg::ST_KNOWN, 2, 32'h0A00_0004, 0, 0));
		directed.push_back(mk_vector(tlt_pkg::KIND_LOCAL, 0, 0, 32'h0000_0005,
			tlt_pkg::MIN_LEN + 1, 1, tlt_pkg::ST_FORWARDED, 3, 32'h0A00_0005,
			32'h0102_0304, 16'd1001));
		repeat (9)
			directed.push_back(mk_vector(tlt_pkg::KIND_TICK, 0, 0, 0, 0, 0,
				tlt_pkg::ST_TICK_DONE, 0, 0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer(directed[i].pkt, directed[i].typed, directed[i].want);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			fill = 1'b0;
			mix = 200;
			base = $urandom;
			case (ph)
				0: begin
					ttl = '1;
					per = '1;
					base = 32'hFFFF_FFF0;
					fill = 1'b1;
					mix = 100;
				end
				1: begin
					ttl = '0;
					per = '0;
					base = '0;
				end
				2: begin
					ttl = tlt_pkg::TTL_W'(1);
					per = tlt_pkg::PERIOD_W'(1);
				end
				3: begin
					ttl = tlt_pkg::TTL_W'($urandom_range(2, 40));
					per = tlt_pkg::PERIOD_W'($urandom_range(2, 12));
				end
				4: begin
					ttl = tlt_pkg::TTL_RESET;
					per = tlt_pkg::PERIOD_RESET;
					mix = 170;
				end
				default: begin
					ttl = tlt_pkg::TTL_W'($urandom_range(1, 65535));
					per = tlt_pkg::PERIOD_W'($urandom_range(1, 255));
					mix = 170;
				end
			endcase
			program_regs(ttl, per, base);
			send_idle = (ph < 2) ? 20 : (ph < 4) ? 80 : 0;
			recv_idle = (ph < 2) ? 80 : (ph < 4) ? 20 : 0;

			// claim every slot with fresh remotes, then run past the end
			if (fill)
				for (int n = 0; n < tlt_pkg::POOL_SIZE + 2; n++) begin
					p = '{kind: tlt_pkg::KIND_REMOTE,
						rip: 32'hAC10_0000 + tlt_pkg::IP_W'(n),
						rport: tlt_pkg::PORT_W'($urandom), dip: $urandom,
						plen: tlt_pkg::LEN_W'($urandom)};
					offer(p, 1'b0, '0);
				end

			for (int n = 0; n < mix; n++) begin
				if ($urandom_range(0, 99) == 0)
					settle();
				offer(draw_packet(), 1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN_HOLD) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
src/tlt_pkg.sv
src/tlt_ram.sv
src/tunnel_lease_table_with_aging_top.sv
bench/tb.sv
